// ===== rtl/acm_pkg.sv =====
// Shared types, codes and helper function of the collision-checked box mover.
package acm_pkg;

  // Default table depth and fixed field widths.
  localparam int ACM_MAX_BOXES = 16;
  localparam int COORD_W       = 16;
  localparam int EXT_W         = 15;
  localparam int INDEX_W       = 4;
  localparam int COUNT_W       = 5;
  localparam int STATUS_W      = 2;

  // Item modes.
  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_MOVE = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_BLOCKED = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  // One stored box as it sits in the table memory.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [EXT_W-1:0]          w;
    logic [EXT_W-1:0]          h;
  } box_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic add_wr;
    logic reject;
    logic mover_lat;
    logic scan_clr;
    logic calc;
    logic scan_en;
    logic commit;
    logic res_load;
  } acm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_move;
    logic full;
    logic idx_bad;
    logic scan_done;
  } acm_sts_t;

  // Adds an offset to a coordinate and clamps the sum to the 16-bit signed range.
  function automatic logic signed [COORD_W-1:0] sat_add(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W:0] s;
    logic signed [COORD_W-1:0] r;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      r = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r = s[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/acm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module acm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/acm_dp.sv =====
// Datapath: box table, mover registers, overlap test and result registers.
module acm_dp import acm_pkg::*; #(
  parameter int MAX_BOXES = ACM_MAX_BOXES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  acm_cmd_t                   cmd,
  output acm_sts_t                   sts,
  input  logic                       mode,
  input  logic [INDEX_W-1:0]         entry_index,
  input  logic signed [COORD_W-1:0]  new_x,
  input  logic signed [COORD_W-1:0]  new_y,
  input  logic [EXT_W-1:0]           new_width,
  input  logic [EXT_W-1:0]           new_height,
  input  logic signed [COORD_W-1:0]  move_dx,
  input  logic signed [COORD_W-1:0]  move_dy,
  output logic [STATUS_W-1:0]        status,
  output logic [COUNT_W-1:0]         entry_count,
  output logic signed [COORD_W-1:0]  out_x,
  output logic signed [COORD_W-1:0]  out_y
);

  localparam int IDX_W = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int SUM_W = COORD_W + 2;

  // Latched input beat.
  logic                      mode_r;
  logic [INDEX_W-1:0]        idx_r;
  box_t                      add_box;
  logic signed [COORD_W-1:0] dx_r;
  logic signed [COORD_W-1:0] dy_r;

  // Table fill and scan control.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rd_ptr;
  logic [CNT_W-1:0] chk_ptr;
  logic             chk_v;
  logic             hit;

  // Mover and its candidate position.
  box_t                      mover;
  logic signed [COORD_W-1:0] nx;
  logic signed [COORD_W-1:0] ny;
  logic signed [SUM_W-1:0]   nx_end;
  logic signed [SUM_W-1:0]   ny_end;

  // Pending result.
  status_t                   res_status;
  logic signed [COORD_W-1:0] res_x;
  logic signed [COORD_W-1:0] res_y;

  // Memory port signals.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  logic [IDX_W-1:0] mover_addr;
  box_t             ram_wdata;
  box_t             ram_rdata;

  // Overlap test signals.
  logic [CMP_W-1:0]        idx_ext;
  logic [CMP_W-1:0]        cnt_ext;
  logic [CMP_W-1:0]        ptr_ext;
  logic signed [SUM_W-1:0] bx_s;
  logic signed [SUM_W-1:0] by_s;
  logic signed [SUM_W-1:0] bx_end;
  logic signed [SUM_W-1:0] by_end;
  logic signed [SUM_W-1:0] nx_s;
  logic signed [SUM_W-1:0] ny_s;
  logic                    x_meet;
  logic                    y_meet;
  logic                    overlap;
  logic                    not_full_scan;

  // Index and count comparisons at a common width.
  assign idx_ext       = CMP_W'(idx_r);
  assign cnt_ext       = CMP_W'(count);
  assign ptr_ext       = CMP_W'(chk_ptr);
  assign mover_addr    = IDX_W'(idx_r);
  assign not_full_scan = rd_ptr < count;

  // Status toward the controller.
  always_comb begin
    sts.is_move   = mode_r == MODE_MOVE;
    sts.full      = count == CNT_W'(MAX_BOXES);
    sts.idx_bad   = idx_ext >= cnt_ext;
    sts.scan_done = (rd_ptr == count) && !chk_v;
  end

  // Memory ports: adds append at the count, unblocked moves write the mover back.
  always_comb begin
    ram_we    = cmd.add_wr | (cmd.commit & ~hit);
    ram_waddr = cmd.add_wr ? count[IDX_W-1:0] : mover_addr;
    ram_wdata = cmd.add_wr ? add_box : box_t'{x: nx, y: ny, w: mover.w, h: mover.h};
    ram_raddr = cmd.scan_en ? rd_ptr[IDX_W-1:0] : mover_addr;
  end

  acm_ram #(
    .WIDTH ($bits(box_t)),
    .DEPTH (MAX_BOXES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Inclusive-edge overlap of the stored box on the read port and the moved box.
  always_comb begin
    bx_s    = {{2{ram_rdata.x[COORD_W-1]}}, ram_rdata.x};
    by_s    = {{2{ram_rdata.y[COORD_W-1]}}, ram_rdata.y};
    bx_end  = bx_s + {3'b000, ram_rdata.w};
    by_end  = by_s + {3'b000, ram_rdata.h};
    nx_s    = {{2{nx[COORD_W-1]}}, nx};
    ny_s    = {{2{ny[COORD_W-1]}}, ny};
    x_meet  = ((bx_s <= nx_s) && (nx_s <= bx_end)) || ((nx_s <= bx_s) && (bx_s <= nx_end));
    y_meet  = ((by_s <= ny_s) && (ny_s <= by_end)) || ((ny_s <= by_s) && (by_s <= ny_end));
    overlap = x_meet && y_meet;
  end

  // Control registers: table count and scan pipeline valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      chk_v <= 1'b0;
    end else begin
      if (cmd.add_wr) begin
        count <= count + CNT_W'(1);
      end
      chk_v <= cmd.scan_en && not_full_scan;
    end
  end

  // Payload registers: input beat, mover, scan, result and output.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r  <= mode;
      idx_r   <= entry_index;
      add_box <= '{x: new_x, y: new_y, w: new_width, h: new_height};
      dx_r    <= move_dx;
      dy_r    <= move_dy;
    end
    if (cmd.mover_lat) begin
      mover <= ram_rdata;
      nx    <= sat_add(ram_rdata.x, dx_r);
      ny    <= sat_add(ram_rdata.y, dy_r);
    end
    if (cmd.calc) begin
      nx_end <= nx_s + {3'b000, mover.w};
      ny_end <= ny_s + {3'b000, mover.h};
    end
    if (cmd.scan_clr) begin
      rd_ptr <= '0;
      hit    <= 1'b0;
    end else begin
      if (cmd.scan_en && not_full_scan) begin
        rd_ptr <= rd_ptr + CNT_W'(1);
      end
      if (chk_v && overlap && (ptr_ext != idx_ext)) begin
        hit <= 1'b1;
      end
    end
    chk_ptr <= rd_ptr;
    if (cmd.add_wr) begin
      res_status <= ST_DONE;
      res_x      <= add_box.x;
      res_y      <= add_box.y;
    end else if (cmd.reject) begin
      res_status <= sts.is_move ? ST_UNUSED : ST_FULL;
      res_x      <= '0;
      res_y      <= '0;
    end else if (cmd.commit) begin
      res_status <= hit ? ST_BLOCKED : ST_DONE;
      res_x      <= hit ? mover.x : nx;
      res_y      <= hit ? mover.y : ny;
    end
    if (cmd.res_load) begin
      status      <= res_status;
      entry_count <= COUNT_W'(count);
      out_x       <= res_x;
      out_y       <= res_y;
    end
  end

endmodule

// ===== rtl/acm_ctrl.sv =====
// Controller: sequences decode, mover read, table scan, write-back and result beat.
module acm_ctrl import acm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  acm_sts_t sts,
  output acm_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MREAD,
    S_MCALC,
    S_SCAN,
    S_WRITE,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // An input beat is taken only between items.
  assign in_stall = state != S_IDLE;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.is_move && !sts.full) begin
          cmd.add_wr = 1'b1;
          state_next = S_RESULT;
        end else if (!sts.is_move || sts.idx_bad) begin
          cmd.reject = 1'b1;
          state_next = S_RESULT;
        end else begin
          state_next = S_MREAD;
        end
      end
      S_MREAD: begin
        cmd.mover_lat = 1'b1;
        cmd.scan_clr  = 1'b1;
        state_next    = S_MCALC;
      end
      S_MCALC: begin
        cmd.calc   = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.commit = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid || !out_stall) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The output register holds its beat until it is taken.
  assign out_valid_next = cmd.res_load | (out_valid & out_stall);

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/aabb_collision_checked_mover.sv =====
// Adds and rejected items go from decode straight to the result state; a move also
// passes through mover read, mover calc, table scan and write-back, the scan growing
// with N, the stored box count, as the single read port scans one stored box per cycle.
// A new item is taken only after the previous one has loaded its result beat.
// Reset clears the box count and the handshake state; table contents are not cleared.
// Top level of the collision-checked box mover.
module aabb_collision_checked_mover import acm_pkg::*; #(
  parameter int MAX_BOXES = ACM_MAX_BOXES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      mode,
  input  logic [INDEX_W-1:0]        entry_index,
  input  logic signed [COORD_W-1:0] new_x,
  input  logic signed [COORD_W-1:0] new_y,
  input  logic [EXT_W-1:0]          new_width,
  input  logic [EXT_W-1:0]          new_height,
  input  logic signed [COORD_W-1:0] move_dx,
  input  logic signed [COORD_W-1:0] move_dy,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [STATUS_W-1:0]       status,
  output logic [COUNT_W-1:0]        entry_count,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y
);

  acm_cmd_t cmd;
  acm_sts_t sts;

  // Sequencing.
  acm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table, overlap test and result registers.
  acm_dp #(
    .MAX_BOXES (MAX_BOXES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .mode        (mode),
    .entry_index (entry_index),
    .new_x       (new_x),
    .new_y       (new_y),
    .new_width   (new_width),
    .new_height  (new_height),
    .move_dx     (move_dx),
    .move_dy     (move_dy),
    .status      (status),
    .entry_count (entry_count),
    .out_x       (out_x),
    .out_y       (out_y)
  );

endmodule

// ===== dv/aabb_collision_checked_mover_test.sv =====
// Self-checking testbench for the collision-checked box mover, with a predicting scoreboard.
module aabb_collision_checked_mover_test;
  import acm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 1732;
  localparam int TAIL_ITEMS     = 200;
  localparam int DRAIN_AT       = 900;
  localparam int LONG_HOLD_AT   = 400;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  // One result beat as the block should present it.
  typedef struct packed {
    status_t                   st;
    logic [COUNT_W-1:0]        cnt;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } move_result_t;

  // Keeps its own copy of the box table and the results still owed by the block.
  class box_table_scoreboard;
    logic signed [COORD_W-1:0] pos_x [ACM_MAX_BOXES];
    logic signed [COORD_W-1:0] pos_y [ACM_MAX_BOXES];
    logic [EXT_W-1:0]          ext_w [ACM_MAX_BOXES];
    logic [EXT_W-1:0]          ext_h [ACM_MAX_BOXES];
    int unsigned               count;
    int                        errors;
    move_result_t              expected_q [$];

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    static function int clamp_coord(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // Closed intervals [a, a + aw] and [b, b + bw] share at least one point.
    static function bit spans_touch(int a, int aw, int b, int bw);
      return (a <= b && b <= a + aw) || (b <= a && a <= b + bw);
    endfunction

    // Applies one accepted input beat to the table and queues the result it causes.
    function void note_item(logic m, logic [INDEX_W-1:0] idx,
                            logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                            logic [EXT_W-1:0] w, logic [EXT_W-1:0] h,
                            logic signed [COORD_W-1:0] dx, logic signed [COORD_W-1:0] dy);
      move_result_t r;
      int nx;
      int ny;
      bit hit;
      r = '0;
      r.st = ST_DONE;
      hit = 1'b0;
      if (m == MODE_ADD) begin
        if (count < ACM_MAX_BOXES) begin
          pos_x[count] = x;
          pos_y[count] = y;
          ext_w[count] = w;
          ext_h[count] = h;
          r.x = x;
          r.y = y;
          count++;
        end else begin
          r.st = ST_FULL;
        end
      end else if (int'(idx) >= count) begin
        r.st = ST_UNUSED;
      end else begin
        nx = clamp_coord(int'(pos_x[idx]) + int'(dx));
        ny = clamp_coord(int'(pos_y[idx]) + int'(dy));
        // The mover is skipped by its index, never by its coordinates.
        for (int i = 0; i < count; i++) begin
          if (i != int'(idx) &&
              spans_touch(int'(pos_x[i]), int'(ext_w[i]), nx, int'(ext_w[idx])) &&
              spans_touch(int'(pos_y[i]), int'(ext_h[i]), ny, int'(ext_h[idx]))) begin
            hit = 1'b1;
          end
        end
        if (hit) begin
          r.st = ST_BLOCKED;
        end else begin
          pos_x[idx] = COORD_W'(nx);
          pos_y[idx] = COORD_W'(ny);
        end
        r.x = pos_x[idx];
        r.y = pos_y[idx];
      end
      r.cnt = COUNT_W'(count);
      expected_q.push_back(r);
    endfunction

    // Compares one accepted result beat with the oldest expectation.
    function void check_result(logic [STATUS_W-1:0] st, logic [COUNT_W-1:0] cnt,
                               logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
      move_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: status %0d count %0d x %0d y %0d",
                 $time, st, cnt, x, y);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (st !== want.st) begin
        $display("%0t: status expected %0d, got %0d", $time, want.st, st);
        errors++;
      end
      if (cnt !== want.cnt) begin
        $display("%0t: entry_count expected %0d, got %0d", $time, want.cnt, cnt);
        errors++;
      end
      if (x !== want.x) begin
        $display("%0t: out_x expected %0d, got %0d", $time, want.x, x);
        errors++;
      end
      if (y !== want.y) begin
        $display("%0t: out_y expected %0d, got %0d", $time, want.y, y);
        errors++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic                      mode;
  logic [INDEX_W-1:0]        entry_index;
  logic signed [COORD_W-1:0] new_x;
  logic signed [COORD_W-1:0] new_y;
  logic [EXT_W-1:0]          new_width;
  logic [EXT_W-1:0]          new_height;
  logic signed [COORD_W-1:0] move_dx;
  logic signed [COORD_W-1:0] move_dy;
  logic                      out_valid;
  logic                      out_stall;
  logic [STATUS_W-1:0]       status;
  logic [COUNT_W-1:0]        entry_count;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;

  box_table_scoreboard sb = new();
  bit                  tail_phase = 1'b0;

  aabb_collision_checked_mover dut (.*);

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Presents one input beat and waits until the block takes it.
  task automatic drive_item(input logic m, input logic [INDEX_W-1:0] idx,
                            input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic [EXT_W-1:0] w, input logic [EXT_W-1:0] h,
                            input logic signed [COORD_W-1:0] dx,
                            input logic signed [COORD_W-1:0] dy);
    in_valid    <= 1'b1;
    mode        <= m;
    entry_index <= idx;
    new_x       <= x;
    new_y       <= y;
    new_width   <= w;
    new_height  <= h;
    move_dx     <= dx;
    move_dy     <= dy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(m, idx, x, y, w, h, dx, dy);
  endtask

  // Input side: reset, directed beats, random beats, then the final verdict.
  initial begin : stimulus
    int                        k;
    int                        calm;
    int                        pick;
    logic                      m;
    logic [INDEX_W-1:0]        idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic [EXT_W-1:0]          w;
    logic [EXT_W-1:0]          h;
    calm = 0;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    mode        <= MODE_ADD;
    entry_index <= '0;
    new_x       <= '0;
    new_y       <= '0;
    new_width   <= '0;
    new_height  <= '0;
    move_dx     <= '0;
    move_dy     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, field extremes, saturation, touching edges, self exclusion.
    drive_item(MODE_MOVE, 4'd0, 0, 0, 0, 0, 5, 5);
    drive_item(MODE_ADD, 4'd0, -32768, -32768, 0, 0, 0, 0);
    drive_item(MODE_ADD, 4'd0, 32767, 32767, 15'h7fff, 15'h7fff, 0, 0);
    drive_item(MODE_MOVE, 4'd2, 0, 0, 0, 0, 0, 0);
    drive_item(MODE_MOVE, 4'd15, 0, 0, 0, 0, 0, 0);
    drive_item(MODE_MOVE, 4'd0, 0, 0, 0, 0, -32768, -32768);
    drive_item(MODE_MOVE, 4'd0, 0, 0, 0, 0, 32767, 32767);
    drive_item(MODE_MOVE, 4'd1, 0, 0, 0, 0, 32767, 32767);
    drive_item(MODE_MOVE, 4'd1, 0, 0, 0, 0, -32768, 0);
    drive_item(MODE_ADD, 4'd0, 0, 0, 10, 10, 0, 0);
    drive_item(MODE_ADD, 4'd0, 20, 0, 5, 5, 0, 0);
    drive_item(MODE_MOVE, 4'd3, 0, 0, 0, 0, -10, 0);
    drive_item(MODE_MOVE, 4'd3, 0, 0, 0, 0, -9, 0);
    drive_item(MODE_MOVE, 4'd3, 0, 0, 0, 0, -1, 10);
    drive_item(MODE_MOVE, 4'd2, 0, 0, 0, 0, 0, 0);
    drive_item(MODE_MOVE, 4'd2, 0, 0, 0, 0, -1, -1);
    drive_item(MODE_ADD, 4'd0, -32768, 32767, 15'h7fff, 0, 0, 0);
    drive_item(MODE_MOVE, 4'd4, 0, 0, 0, 0, 0, -32768);

    // Random: small boxes clustered near the origin so moves both pass and collide.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS - TAIL_ITEMS) tail_phase = 1'b1;
      if (k == DRAIN_AT) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end else if (!tail_phase) begin
        if (calm > 0) begin
          calm--;
        end else if ($urandom_range(0, 24) == 0) begin
          calm = $urandom_range(15, 60);
        end else if ($urandom_range(0, 2) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 11)) @(posedge clk);
        end
      end

      pick = $urandom_range(0, 99);
      if (sb.count < ACM_MAX_BOXES) begin
        m = (pick < 30) ? MODE_ADD : MODE_MOVE;
      end else begin
        m = (pick < 8) ? MODE_ADD : MODE_MOVE;
      end
      idx = INDEX_W'($urandom_range(0, 15));
      x   = COORD_W'($urandom);
      y   = COORD_W'($urandom);
      w   = EXT_W'($urandom);
      h   = EXT_W'($urandom);
      dx  = COORD_W'($urandom);
      dy  = COORD_W'($urandom);

      if (m == MODE_ADD && sb.count < ACM_MAX_BOXES) begin
        x = COORD_W'($urandom_range(0, 600) - 300);
        y = COORD_W'($urandom_range(0, 600) - 300);
        w = EXT_W'($urandom_range(0, 60));
        h = EXT_W'($urandom_range(0, 60));
      end else if (m == MODE_MOVE) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          dx = COORD_W'($urandom_range(0, 80) - 40);
          dy = COORD_W'($urandom_range(0, 80) - 40);
        end else if (pick < 75) begin
          dx = COORD_W'($urandom_range(0, 600) - 300);
          dy = COORD_W'($urandom_range(0, 600) - 300);
        end else if (pick < 85) begin
          // Offsets at the range limits drive the coordinates into saturation.
          dx = ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
          dy = ($urandom_range(0, 2) == 0) ? 16'sh0000 :
               (($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000);
        end else if (pick < 90) begin
          dx = '0;
          dy = '0;
        end
      end
      drive_item(m, idx, x, y, w, h, dx, dy);
    end
    in_valid <= 1'b0;

    // Let the last results drain, then give the block time to show any stray beat.
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("aabb_collision_checked_mover test passed");
    end else begin
      $display("aabb_collision_checked_mover test failed");
    end
    $finish;
  end

  // Output side: checks every accepted result beat and applies random back-pressure.
  initial begin : result_sink
    int stall_left;
    int calm_left;
    int results_seen;
    bit long_hold_done;
    stall_left     = 0;
    calm_left      = 0;
    results_seen   = 0;
    long_hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        sb.check_result(status, entry_count, out_x, out_y);
        results_seen++;
      end
      // One long hold-off so the block backs up and stalls its input.
      if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD;
      end
      if (tail_phase) begin
        stall_left = 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!tail_phase) begin
          if (calm_left > 0) begin
            calm_left--;
          end else if ($urandom_range(0, 29) == 0) begin
            calm_left = $urandom_range(20, 80);
          end else if ($urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 11);
          end
        end
      end
    end
  end

  // Ends the run when no beat moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("aabb_collision_checked_mover test failed");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
rtl/acm_pkg.sv
rtl/acm_ram.sv
rtl/acm_dp.sv
rtl/acm_ctrl.sv
rtl/aabb_collision_checked_mover.sv
dv/aabb_collision_checked_mover_test.sv
